FILE: rtl/qs_pkg.sv
// ----------------------------------------------------------------------------
// qs_pkg
// Shared word type and per-cell control bundle for the sorting cell chain.
// ----------------------------------------------------------------------------
package qs_pkg;

  localparam int unsigned DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

FILE: rtl/qs_cell.sv
// ----------------------------------------------------------------------------
// qs_cell
// One sorting cell: holds one word, takes part in ordered insertion and
// hands its word to the lower neighbor while draining.
// ----------------------------------------------------------------------------
module qs_cell (
  input  logic               clk,
  input  logic               rst,
  input  qs_pkg::cell_ctrl_t ctrl,
  input  qs_pkg::data_t      ins_word,
  input  qs_pkg::data_t      prev_word,
  input  logic               prev_occ,
  input  logic               prev_ins,
  input  qs_pkg::data_t      next_word,
  input  logic               next_occ,
  output qs_pkg::data_t      word,
  output logic               occ,
  output logic               ins
);

  assign ins = !occ || (ins_word < word);

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctrl.shift) begin
      occ <= next_occ;
    end else if (ctrl.insert && ins) begin
      occ <= occ | prev_occ;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      word <= next_word;
    end else if (ctrl.insert && ins) begin
      word <= prev_ins ? prev_word : ins_word;
    end
  end

endmodule

FILE: rtl/quicksort_engine.sv
// ----------------------------------------------------------------------------
// quicksort_engine
// Streaming sorter for signed 32-bit words built as a chain of sorting cells.
// ----------------------------------------------------------------------------
// Words enter one per cycle while not stalled and are inserted in ascending
// order into a chain of CAPACITY cells, so the set is already sorted when
// the word marked last is taken. Words arriving while all cells are full are
// dropped; a dropped word marked last still closes the set. The chain then
// shifts toward cell zero, presenting one sorted word per cycle that the
// output is not stalled, with end_of_set on the final one. Input is stalled
// for the drain only, and the next set may start in the cycle after the
// final word is taken.
module quicksort_engine #(
  parameter int CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  qs_pkg::data_t value,
  input  logic          last,
  output logic          out_valid,
  input  logic          out_stall,
  output qs_pkg::data_t sorted_value,
  output logic          end_of_set
);

  typedef enum logic [1:0] {
    LOAD  = 2'b01,
    DRAIN = 2'b10
  } mode_t;

  mode_t mode;
  mode_t mode_next;

  qs_pkg::data_t      words [CAPACITY];
  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] ins;
  qs_pkg::cell_ctrl_t  ctrl;
  logic                take;
  logic                give;

  assign in_stall = (mode != LOAD);
  assign take     = in_valid && !in_stall;
  assign out_valid = (mode == DRAIN) && occ[0];
  assign give     = out_valid && !out_stall;

  assign ctrl.insert = take && !occ[CAPACITY-1];
  assign ctrl.shift  = give;

  assign sorted_value = words[0];
  assign end_of_set   = !occ[1];

  always_comb begin
    mode_next = mode;
    unique case (mode)
      LOAD: begin
        if (take && last) mode_next = DRAIN;
      end
      DRAIN: begin
        if (give && !occ[1]) mode_next = LOAD;
      end
      default: mode_next = LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= LOAD;
    end else begin
      mode <= mode_next;
    end
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      qs_pkg::data_t prev_word;
      logic          prev_occ;
      logic          prev_ins;
      qs_pkg::data_t next_word;
      logic          next_occ;

      if (i == 0) begin : g_head
        assign prev_word = value;
        assign prev_occ  = 1'b1;
        assign prev_ins  = 1'b0;
      end else begin : g_body
        assign prev_word = words[i-1];
        assign prev_occ  = occ[i-1];
        assign prev_ins  = ins[i-1];
      end

      if (i == CAPACITY-1) begin : g_tail
        assign next_word = words[i];
        assign next_occ  = 1'b0;
      end else begin : g_link
        assign next_word = words[i+1];
        assign next_occ  = occ[i+1];
      end

      qs_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .ins_word  (value),
        .prev_word (prev_word),
        .prev_occ  (prev_occ),
        .prev_ins  (prev_ins),
        .next_word (next_word),
        .next_occ  (next_occ),
        .word      (words[i]),
        .occ       (occ[i]),
        .ins       (ins[i])
      );
    end
  endgenerate

endmodule
